[hdl/bta_pkg.sv]
// Shared types, constants and helper functions for the balanced ternary ALU.
`timescale 1ns / 1ps

package bta_pkg;

  localparam int NUM_TRITS_DEF = 64;
  localparam int WORD_W        = 64;
  localparam int REQ_W         = 3;
  // Any signed 64-bit value fits in 41 balanced trits.
  localparam int FI_TRITS      = 41;
  localparam int FI_IDX_W      = $clog2(FI_TRITS);
  localparam int VAL_W         = WORD_W + 1;

  typedef enum logic [REQ_W-1:0] {
    OP_ADD      = 3'd0,
    OP_SUB      = 3'd1,
    OP_NEG      = 3'd2,
    OP_FROM_INT = 3'd3,
    OP_TO_INT   = 3'd4
  } op_t;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t pow3_tab_t [FI_TRITS];

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } bta_cmd_t;

  typedef struct packed {
    logic done;
  } bta_stat_t;

  function automatic pow3_tab_t pow3_table();
    pow3_tab_t tab;
    word_t     p;
    p = word_t'(1);
    for (int i = 0; i < FI_TRITS; i++) begin
      tab[i] = p;
      p      = p * word_t'(3);
    end
    return tab;
  endfunction

  function automatic pow3_tab_t half3_table();
    pow3_tab_t tab;
    pow3_tab_t pw;
    pw = pow3_table();
    for (int i = 0; i < FI_TRITS; i++) begin
      tab[i] = (pw[i] - word_t'(1)) >> 1;
    end
    return tab;
  endfunction

  // A forbidden pair reads as minus one.
  function automatic logic signed [1:0] trit_val(input logic mn, input logic pl);
    logic signed [1:0] t;
    if (mn) begin
      t = -2'sd1;
    end else if (pl) begin
      t = 2'sd1;
    end else begin
      t = 2'sd0;
    end
    return t;
  endfunction

endpackage

[hdl/bta_if.sv]
// Request and result channel interfaces of the balanced ternary ALU.
`timescale 1ns / 1ps

interface bta_req_if import bta_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  word_t              a_minus;
  word_t              a_plus;
  word_t              b_minus;
  word_t              b_plus;
  logic signed [WORD_W-1:0] int_value;

  modport source (output valid, req_type, a_minus, a_plus, b_minus, b_plus, int_value,
                  input ready);
  modport sink (input valid, req_type, a_minus, a_plus, b_minus, b_plus, int_value,
                output ready);
endinterface

interface bta_res_if import bta_pkg::*; ();
  logic               valid;
  logic               ready;
  word_t              tern_minus;
  word_t              tern_plus;
  logic signed [WORD_W-1:0] int_result;
  logic               invalid_input;

  modport source (output valid, tern_minus, tern_plus, int_result, invalid_input,
                  input ready);
  modport sink (input valid, tern_minus, tern_plus, int_result, invalid_input,
                output ready);
endinterface

[hdl/bta_ctrl.sv]
// Controller state machine that sequences load, trit steps and result hand-off.
`timescale 1ns / 1ps

module bta_ctrl import bta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bta_stat_t stat,
  output bta_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stat.done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/bta_dp.sv]
// Datapath: operand shifters, trit adder, conversion steps and result register.
`timescale 1ns / 1ps

module bta_dp import bta_pkg::*; #(
  parameter int NUM_TRITS = NUM_TRITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bta_cmd_t                 cmd,
  output bta_stat_t                stat,
  input  logic [REQ_W-1:0]         req_type,
  input  word_t                    a_minus,
  input  word_t                    a_plus,
  input  word_t                    b_minus,
  input  word_t                    b_plus,
  input  logic signed [WORD_W-1:0] int_value,
  output word_t                    tern_minus,
  output word_t                    tern_plus,
  output logic signed [WORD_W-1:0] int_result,
  output logic                     invalid_input
);

  localparam int STEP_MAX = (NUM_TRITS > FI_TRITS) ? NUM_TRITS : FI_TRITS;
  localparam int CNT_W    = $clog2(STEP_MAX + 1);
  localparam pow3_tab_t POW3  = pow3_table();
  localparam pow3_tab_t HALF3 = half3_table();

  logic [REQ_W-1:0]        op_r, op_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [NUM_TRITS-1:0]    am_r, am_nxt, ap_r, ap_nxt;
  logic [NUM_TRITS-1:0]    bm_r, bm_nxt, bp_r, bp_nxt;
  logic [NUM_TRITS-1:0]    rm_r, rm_nxt, rp_r, rp_nxt;
  logic signed [1:0]       carry_r, carry_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    flag_r, flag_nxt;
  word_t                   tern_minus_r, tern_plus_r;
  logic signed [WORD_W-1:0] int_result_r;
  logic                    invalid_r;

  logic                    bad_a, bad_b;
  logic signed [1:0]       ta, tb, tt;
  logic signed [2:0]       sum, digit;
  logic [FI_IDX_W-1:0]     kidx;
  logic signed [VAL_W-1:0] pk, hk;
  word_t                   acc, acc_nxt, t_ext;

  assign bad_a = |(a_minus[NUM_TRITS-1:0] & a_plus[NUM_TRITS-1:0]);
  assign bad_b = |(b_minus[NUM_TRITS-1:0] & b_plus[NUM_TRITS-1:0]);

  // Trit adder on the low end of the operand shifters.
  assign ta  = trit_val(am_r[0], ap_r[0]);
  assign tb  = trit_val(bm_r[0], bp_r[0]);
  assign sum = 3'(ta) + 3'(tb) + 3'(carry_r);

  // Greedy conversion from the top power of three downward.
  assign kidx = FI_IDX_W'(cnt_r - 1'b1);
  assign pk   = $signed({1'b0, POW3[kidx]});
  assign hk   = $signed({1'b0, HALF3[kidx]});

  // Horner evaluation from the top trit of a.
  assign tt      = trit_val(am_r[NUM_TRITS-1], ap_r[NUM_TRITS-1]);
  assign acc     = val_r[WORD_W-1:0];
  assign t_ext   = {{(WORD_W-2){tt[1]}}, tt};
  assign acc_nxt = {acc[WORD_W-2:0], 1'b0} + acc + t_ext;

  assign stat.done = (cnt_r == '0);

  always_comb begin
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    am_nxt    = am_r;
    ap_nxt    = ap_r;
    bm_nxt    = bm_r;
    bp_nxt    = bp_r;
    rm_nxt    = rm_r;
    rp_nxt    = rp_r;
    carry_nxt = carry_r;
    val_nxt   = val_r;
    flag_nxt  = flag_r;
    digit     = sum;
    if (cmd.load) begin
      op_nxt    = req_type;
      am_nxt    = a_minus[NUM_TRITS-1:0];
      ap_nxt    = a_plus[NUM_TRITS-1:0];
      bm_nxt    = b_minus[NUM_TRITS-1:0];
      bp_nxt    = b_plus[NUM_TRITS-1:0];
      rm_nxt    = '0;
      rp_nxt    = '0;
      carry_nxt = 2'sd0;
      val_nxt   = '0;
      flag_nxt  = 1'b0;
      cnt_nxt   = '0;
      unique case (req_type) inside
        OP_ADD: begin
          cnt_nxt  = CNT_W'(NUM_TRITS);
          flag_nxt = bad_a || bad_b;
        end
        OP_SUB: begin
          bm_nxt   = b_plus[NUM_TRITS-1:0];
          bp_nxt   = b_minus[NUM_TRITS-1:0];
          cnt_nxt  = CNT_W'(NUM_TRITS);
          flag_nxt = bad_a || bad_b;
        end
        OP_NEG: begin
          rm_nxt   = a_plus[NUM_TRITS-1:0];
          rp_nxt   = a_minus[NUM_TRITS-1:0];
          flag_nxt = bad_a;
        end
        OP_FROM_INT: begin
          val_nxt = {int_value[WORD_W-1], int_value};
          cnt_nxt = CNT_W'(FI_TRITS);
        end
        OP_TO_INT: begin
          cnt_nxt  = CNT_W'(NUM_TRITS);
          flag_nxt = bad_a;
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end else if (cmd.step) begin
      cnt_nxt = cnt_r - 1'b1;
      case (op_r) inside
        OP_ADD, OP_SUB: begin
          if (sum > 3'sd1) begin
            digit     = sum - 3'sd3;
            carry_nxt = 2'sd1;
          end else if (sum < -3'sd1) begin
            digit     = sum + 3'sd3;
            carry_nxt = -2'sd1;
          end else begin
            carry_nxt = 2'sd0;
          end
          am_nxt = am_r >> 1;
          ap_nxt = ap_r >> 1;
          bm_nxt = bm_r >> 1;
          bp_nxt = bp_r >> 1;
          rm_nxt = {digit < 3'sd0, rm_r[NUM_TRITS-1:1]};
          rp_nxt = {digit > 3'sd0, rp_r[NUM_TRITS-1:1]};
        end
        OP_FROM_INT: begin
          if (val_r > hk) begin
            val_nxt = val_r - pk;
            rm_nxt  = {rm_r[NUM_TRITS-2:0], 1'b0};
            rp_nxt  = {rp_r[NUM_TRITS-2:0], 1'b1};
          end else if (val_r < -hk) begin
            val_nxt = val_r + pk;
            rm_nxt  = {rm_r[NUM_TRITS-2:0], 1'b1};
            rp_nxt  = {rp_r[NUM_TRITS-2:0], 1'b0};
          end else begin
            rm_nxt  = {rm_r[NUM_TRITS-2:0], 1'b0};
            rp_nxt  = {rp_r[NUM_TRITS-2:0], 1'b0};
          end
        end
        OP_TO_INT: begin
          val_nxt = {1'b0, acc_nxt};
          am_nxt  = am_r << 1;
          ap_nxt  = ap_r << 1;
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      op_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      op_r  <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    am_r    <= am_nxt;
    ap_r    <= ap_nxt;
    bm_r    <= bm_nxt;
    bp_r    <= bp_nxt;
    rm_r    <= rm_nxt;
    rp_r    <= rp_nxt;
    carry_r <= carry_nxt;
    val_r   <= val_nxt;
    flag_r  <= flag_nxt;
    if (cmd.publish) begin
      tern_minus_r <= WORD_W'(rm_r);
      tern_plus_r  <= WORD_W'(rp_r);
      int_result_r <= (op_r == OP_TO_INT) ? val_r[WORD_W-1:0] : '0;
      invalid_r    <= flag_r;
    end
  end

  assign tern_minus    = tern_minus_r;
  assign tern_plus     = tern_plus_r;
  assign int_result    = int_result_r;
  assign invalid_input = invalid_r;

endmodule

[hdl/balanced_ternary_alu.sv]
// Top level of the balanced ternary ALU: controller, datapath and channel hookup.
//
// The ALU takes one item at a time and returns one result item for it. Add,
// subtract and to-integer run one trit per cycle through a serial trit adder or
// a Horner accumulator. From-integer steps down a table of 41 powers of three
// with one compare and add per cycle. Negate and unknown request codes run no
// trit steps. The result sits in an output register, so the next item is
// accepted while an earlier result waits.
`timescale 1ns / 1ps

module balanced_ternary_alu import bta_pkg::*; #(
  parameter int NUM_TRITS = NUM_TRITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bta_req_if.sink   in_req,
  bta_res_if.source out_res
);

  bta_cmd_t  cmd;
  bta_stat_t stat;

  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bta_dp #(
    .NUM_TRITS (NUM_TRITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (in_req.req_type),
    .a_minus       (in_req.a_minus),
    .a_plus        (in_req.a_plus),
    .b_minus       (in_req.b_minus),
    .b_plus        (in_req.b_plus),
    .int_value     (in_req.int_value),
    .tern_minus    (out_res.tern_minus),
    .tern_plus     (out_res.tern_plus),
    .int_result    (out_res.int_result),
    .invalid_input (out_res.invalid_input)
  );

endmodule

[tb/bta_checker.sv]
// Checker for the balanced ternary ALU: predicts each result item and compares it.
`timescale 1ns / 1ps

module bta_checker import bta_pkg::*; #(
  parameter int NUM_TRITS = NUM_TRITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bta_req_if   req,
  bta_res_if   res,
  output int   errors,
  output int   pending
);

  localparam word_t TRIT_MASK = {WORD_W{1'b1}} >> (WORD_W - NUM_TRITS);

  typedef struct packed {
    word_t mn;
    word_t pl;
    word_t ival;
    logic  flag;
  } alu_result_t;

  alu_result_t alu_results_due[$];
  int          results_seen;

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
  end

  function automatic int plane_trit(input logic mn, input logic pl);
    if (mn) begin
      return -1;
    end else if (pl) begin
      return 1;
    end
    return 0;
  endfunction

  function automatic void trit_sum(input word_t am, input word_t ap, input word_t bm,
                                   input word_t bp, output word_t rm, output word_t rp);
    int c;
    int s;
    c  = 0;
    rm = '0;
    rp = '0;
    for (int i = 0; i < NUM_TRITS; i++) begin
      s = plane_trit(am[i], ap[i]) + plane_trit(bm[i], bp[i]) + c;
      if (s > 1) begin
        s -= 3;
        c = 1;
      end else if (s < -1) begin
        s += 3;
        c = -1;
      end else begin
        c = 0;
      end
      if (s > 0) begin
        rp[i] = 1'b1;
      end else if (s < 0) begin
        rm[i] = 1'b1;
      end
    end
  endfunction

  function automatic void int_to_trits(input word_t raw, output word_t rm, output word_t rp);
    logic  neg;
    word_t mag;
    word_t q;
    word_t r;
    word_t om;
    word_t op;
    neg = raw[WORD_W-1];
    mag = neg ? (word_t'(0) - raw) : raw;
    om  = '0;
    op  = '0;
    for (int i = 0; i < NUM_TRITS; i++) begin
      r = mag % word_t'(3);
      q = mag / word_t'(3);
      if (r == word_t'(1)) begin
        op[i] = 1'b1;
        mag   = q;
      end else if (r == word_t'(2)) begin
        om[i] = 1'b1;
        mag   = q + word_t'(1);
      end else begin
        mag = q;
      end
    end
    rm = neg ? op : om;
    rp = neg ? om : op;
  endfunction

  function automatic word_t trits_to_int(input word_t mn, input word_t pl);
    word_t acc;
    word_t w;
    acc = '0;
    w   = word_t'(1);
    for (int i = 0; i < NUM_TRITS; i++) begin
      if (plane_trit(mn[i], pl[i]) < 0) begin
        acc -= w;
      end else if (plane_trit(mn[i], pl[i]) > 0) begin
        acc += w;
      end
      w *= word_t'(3);
    end
    return acc;
  endfunction

  function automatic alu_result_t compute_alu_result(input logic [REQ_W-1:0] code,
                                                     input word_t am_raw, input word_t ap_raw,
                                                     input word_t bm_raw, input word_t bp_raw,
                                                     input word_t iv);
    alu_result_t r;
    word_t       am;
    word_t       ap;
    word_t       bm;
    word_t       bp;
    logic        bad_a;
    logic        bad_b;
    am    = am_raw & TRIT_MASK;
    ap    = ap_raw & TRIT_MASK;
    bm    = bm_raw & TRIT_MASK;
    bp    = bp_raw & TRIT_MASK;
    bad_a = |(am & ap);
    bad_b = |(bm & bp);
    r     = '0;
    case (code)
      OP_ADD: begin
        trit_sum(am, ap, bm, bp, r.mn, r.pl);
        r.flag = bad_a | bad_b;
      end
      OP_SUB: begin
        trit_sum(am, ap, bp, bm, r.mn, r.pl);
        r.flag = bad_a | bad_b;
      end
      OP_NEG: begin
        r.mn   = ap;
        r.pl   = am;
        r.flag = bad_a;
      end
      OP_FROM_INT: begin
        int_to_trits(iv, r.mn, r.pl);
      end
      OP_TO_INT: begin
        r.ival = trits_to_int(am, ap);
        r.flag = bad_a;
      end
      default: begin
      end
    endcase
    r.mn &= TRIT_MASK;
    r.pl &= TRIT_MASK;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("ERROR result %0d: %s is %h, expected %h", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) begin
      alu_results_due.delete();
      pending <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (alu_results_due.size() == 0) begin
          report_mismatch("unexpected item", res.tern_minus, '0);
        end else begin
          want = alu_results_due.pop_front();
          if (res.tern_minus !== want.mn) begin
            report_mismatch("tern_minus", res.tern_minus, want.mn);
          end
          if (res.tern_plus !== want.pl) begin
            report_mismatch("tern_plus", res.tern_plus, want.pl);
          end
          if (word_t'(res.int_result) !== want.ival) begin
            report_mismatch("int_result", res.int_result, want.ival);
          end
          if (res.invalid_input !== want.flag) begin
            report_mismatch("invalid_input", word_t'(res.invalid_input), word_t'(want.flag));
          end
        end
        results_seen++;
      end
      if (req.valid && req.ready) begin
        alu_results_due.push_back(compute_alu_result(req.req_type, req.a_minus, req.a_plus,
                                                     req.b_minus, req.b_plus, req.int_value));
      end
      pending <= alu_results_due.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for the balanced ternary ALU: stimulus, result pacing and verdict.
`timescale 1ns / 1ps

module tb;
  import bta_pkg::*;

  localparam logic [REQ_W-1:0] OP_FIRST_UNUSED = REQ_W'(int'(OP_TO_INT) + 1);
  localparam logic [REQ_W-1:0] OP_CODE_LAST    = '1;
  localparam int    RANDOM_ITEMS   = 1280;
  localparam int    HOLD_AT_RESULT = 300;
  localparam int    HOLD_CYCLES    = 600;
  localparam int    TAIL_CYCLES    = NUM_TRITS_DEF + 16;
  localparam word_t ALL_ONES       = '1;
  localparam word_t LSB_ONLY       = word_t'(1);
  localparam word_t MSB_ONLY       = ALL_ONES ^ (ALL_ONES >> 1);

  logic clk = 1'b0;
  logic rst_n;
  int   fail_total;
  int   results_owed;
  int   items_sent = 0;
  int   results_taken = 0;
  int   sent_per_code [2**REQ_W];
  logic sender_quiet = 1'b0;

  bta_req_if in_req ();
  bta_res_if out_res ();

  balanced_ternary_alu i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  bta_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_req),
    .res     (out_res),
    .errors  (fail_total),
    .pending (results_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input logic [REQ_W-1:0] code, input word_t am, input word_t ap,
                           input word_t bm, input word_t bp, input word_t iv);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.req_type  <= code;
    in_req.a_minus   <= am;
    in_req.a_plus    <= ap;
    in_req.b_minus   <= bm;
    in_req.b_plus    <= bp;
    in_req.int_value <= iv;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    sent_per_code[code]++;
  endtask

  task automatic pause_until_drained();
    in_req.valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  task automatic rand_operand(output word_t mn, output word_t pl);
    int style;
    int t;
    int idx;
    style = $urandom_range(0, 19);
    mn    = '0;
    pl    = '0;
    case (style)
      0, 1: begin
        mn = {$urandom(), $urandom()};
        pl = {$urandom(), $urandom()};
      end
      2: pl = ALL_ONES;
      3: mn = ALL_ONES;
      4: begin
        repeat ($urandom_range(1, 4)) begin
          idx = $urandom_range(0, WORD_W - 1);
          if ($urandom_range(0, 1) == 0) begin
            pl[idx] = 1'b1;
          end else begin
            mn[idx] = 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < WORD_W; i++) begin
          t = $urandom_range(0, 2);
          if (t == 1) begin
            pl[i] = 1'b1;
          end else if (t == 2) begin
            mn[i] = 1'b1;
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          idx     = $urandom_range(0, WORD_W - 1);
          mn[idx] = 1'b1;
          pl[idx] = 1'b1;
        end
      end
    endcase
  endtask

  function automatic word_t rand_integer();
    int style;
    style = $urandom_range(0, 5);
    case (style)
      0: return word_t'(longint'($urandom_range(0, 2000)) - 1000);
      1: begin
        case ($urandom_range(0, 3))
          0: return MSB_ONLY;
          1: return ~MSB_ONLY;
          2: return ALL_ONES;
          default: return '0;
        endcase
      end
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    int unused_sent;
    word_t am;
    word_t ap;
    word_t bm;
    word_t bp;
    logic [REQ_W-1:0] code;
    in_req.valid     = 1'b0;
    in_req.req_type  = '0;
    in_req.a_minus   = '0;
    in_req.a_plus    = '0;
    in_req.b_minus   = '0;
    in_req.b_plus    = '0;
    in_req.int_value = '0;
    foreach (sent_per_code[i]) sent_per_code[i] = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_ADD, '0, '0, '0, '0, '0);
    send_item(OP_ADD, '0, ALL_ONES, '0, LSB_ONLY, '0);
    send_item(OP_ADD, ALL_ONES, '0, ALL_ONES, '0, '0);
    send_item(OP_SUB, '0, LSB_ONLY, '0, LSB_ONLY, '0);
    send_item(OP_SUB, '0, '0, '0, ALL_ONES, '0);
    send_item(OP_ADD, ALL_ONES, ALL_ONES, '0, '0, '0);
    send_item(OP_ADD, '0, LSB_ONLY, MSB_ONLY, MSB_ONLY, '0);
    send_item(OP_SUB, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
              64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, '0);
    send_item(OP_NEG, '0, ALL_ONES, '0, '0, '0);
    send_item(OP_NEG, 64'hF0F0_F0F0_F0F0_F0F0, 64'hFF00_FF00_FF00_FF00, '0, '0, '0);
    send_item(OP_FROM_INT, '0, '0, '0, '0, '0);
    send_item(OP_FROM_INT, '0, '0, '0, '0, LSB_ONLY);
    send_item(OP_FROM_INT, '0, '0, '0, '0, ALL_ONES);
    send_item(OP_FROM_INT, '0, '0, '0, '0, ~MSB_ONLY);
    send_item(OP_FROM_INT, '0, '0, '0, '0, MSB_ONLY);
    send_item(OP_FROM_INT, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 64'h0123_4567_89AB_CDEF);
    send_item(OP_TO_INT, '0, ALL_ONES, '0, '0, '0);
    send_item(OP_TO_INT, ALL_ONES, '0, '0, '0, '0);
    send_item(OP_TO_INT, ALL_ONES, ALL_ONES, '0, '0, '0);
    send_item(OP_TO_INT, '0, MSB_ONLY, '0, '0, '0);
    send_item(OP_TO_INT, '0, '0, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(OP_FIRST_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(OP_CODE_LAST - 1'b1, ALL_ONES, '0, '0, ALL_ONES, ALL_ONES);
    send_item(OP_CODE_LAST, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    pause_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sender_quiet = ((n / 200) % 3 == 1);
      if (n == RANDOM_ITEMS / 2) begin
        pause_until_drained();
      end
      if ($urandom_range(0, 99) < 4) begin
        code = REQ_W'($urandom_range(int'(OP_FIRST_UNUSED), int'(OP_CODE_LAST)));
      end else begin
        code = REQ_W'($urandom_range(int'(OP_ADD), int'(OP_TO_INT)));
      end
      rand_operand(am, ap);
      rand_operand(bm, bp);
      send_item(code, am, ap, bm, bp, rand_integer());
    end

    pause_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    unused_sent = 0;
    for (int c = int'(OP_FIRST_UNUSED); c <= int'(OP_CODE_LAST); c++) begin
      unused_sent += sent_per_code[c];
    end
    $display("Covered %0d items: add %0d, subtract %0d, negate %0d,",
             items_sent, sent_per_code[OP_ADD], sent_per_code[OP_SUB], sent_per_code[OP_NEG]);
    $display("from-int %0d, to-int %0d, unknown %0d.",
             sent_per_code[OP_FROM_INT], sent_per_code[OP_TO_INT], unused_sent);
    $display("Checked %0d result items, with one receiver hold-off of %0d cycles.",
             results_taken, HOLD_CYCLES);
    if (fail_total == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int wait_cycles;
    out_res.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (results_taken == HOLD_AT_RESULT) begin
        wait_cycles = HOLD_CYCLES;
      end else if ((results_taken / 170) % 3 == 2) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 14);
      end
      if (wait_cycles > 0) begin
        out_res.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_res.ready <= 1'b1;
      @(posedge clk);
      while (!out_res.valid) @(posedge clk);
      @(negedge clk);
      results_taken++;
    end
  end

endmodule
